// ===== rtl/core/nce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nce_pkg
// Shared widths, register indexes and constants of the nonzero coordinate
// extractor.
// ----------------------------------------------------------------------------
package nce_pkg;

  localparam int ELEM_W      = 32;  // element value
  localparam int OUT_W       = 16;  // reported coordinate
  localparam int AXIS_W      = 3;   // axis number
  localparam int RANK_W      = 3;   // rank register
  localparam int EXT_W       = 16;  // extent registers
  localparam int EXT_REGS    = 6;   // axes that have an extent register
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;   // front-to-back entries

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK = 3'd0,
    REG_EXT0 = 3'd1,
    REG_EXT1 = 3'd2,
    REG_EXT2 = 3'd3,
    REG_EXT3 = 3'd4,
    REG_EXT4 = 3'd5,
    REG_EXT5 = 3'd6
  } nce_reg_e;

endpackage

// ===== rtl/core/nce_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nce_if
// Valid/ready channels of the nonzero coordinate extractor: element input,
// coordinate output and register write.
// ----------------------------------------------------------------------------
interface nce_elem_if;
  import nce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  logic                     first_element;

  modport source (output valid, element_value, first_element, input ready);
  modport sink   (input valid, element_value, first_element, output ready);
endinterface

interface nce_coord_if;
  import nce_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  coordinate;
  logic [AXIS_W-1:0] axis;
  logic              last_axis;

  modport source (output valid, coordinate, axis, last_axis, input ready);
  modport sink   (input valid, coordinate, axis, last_axis, output ready);
endinterface

interface nce_cfg_if;
  import nce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/nce_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nce_front
// Config registers and the per-axis odometer. Takes one element per cycle
// while the queue has room, queueing a coordinate snapshot per nonzero element.
// ----------------------------------------------------------------------------
module nce_front #(
  parameter int MAX_DIMS    = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  nce_elem_if.sink                                  elem_i,
  nce_cfg_if.sink                                   cfg_i,
  input  logic                                      q_full_i,
  output logic                                      q_push_o,
  output logic [MAX_DIMS-1:0][nce_pkg::OUT_W-1:0]   q_coords_o,
  output logic [nce_pkg::RANK_W-1:0]                q_rank_o
);
  import nce_pkg::*;

  logic [RANK_W-1:0]                     rank_q;
  logic [EXT_REGS-1:0][EXT_W-1:0]        ext_q;
  logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]  cnt_q, cnt_d, base, nxt;
  logic [MAX_DIMS-1:0]                   wrap, inc, in_rank;
  logic [RANK_W-1:0]                     act_rank;
  logic                                  accept;
  logic                                  carry;

  assign accept       = elem_i.valid && elem_i.ready;
  assign elem_i.ready = !q_full_i;
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    if (rank_q == '0) begin
      act_rank = RANK_W'(1);
    end else if (32'(rank_q) > MAX_DIMS) begin
      act_rank = RANK_W'(MAX_DIMS);
    end else begin
      act_rank = rank_q;
    end
  end

  for (genvar a = 0; a < MAX_DIMS; a++) begin : g_axis
    logic [EXT_W-1:0] ext;
    if (a < EXT_REGS) begin : g_reg
      assign ext = (ext_q[a] == '0) ? EXT_W'(1) : ext_q[a];
    end else begin : g_one
      assign ext = EXT_W'(1);
    end
    assign base[a]       = elem_i.first_element ? '0 : cnt_q[a];
    assign nxt[a]        = base[a] + COORD_WIDTH'(1);
    assign wrap[a]       = (32'(nxt[a]) >= 32'(ext)) || (nxt[a] == '0);
    assign in_rank[a]    = (a < int'(act_rank));
    assign q_coords_o[a] = OUT_W'(base[a]);
    assign cnt_d[a]      = (in_rank[a] && inc[a]) ? (wrap[a] ? '0 : nxt[a]) : base[a];
  end

  // innermost axis always steps; carry ripples outward through wrapping axes
  always_comb begin
    carry = 1'b1;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      inc[k] = carry && in_rank[k];
      if (in_rank[k]) begin
        carry = carry && wrap[k];
      end
    end
  end

  assign q_push_o = accept && (elem_i.element_value != '0);
  assign q_rank_o = act_rank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(1);
      for (int e = 0; e < EXT_REGS; e++) begin
        ext_q[e] <= EXT_W'(1);
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.reg_index == REG_RANK) begin
        rank_q <= cfg_i.wdata[RANK_W-1:0];
      end
      for (int e = 0; e < EXT_REGS; e++) begin
        if (cfg_i.reg_index == (CFG_IDX_W'(REG_EXT0) + CFG_IDX_W'(e))) begin
          ext_q[e] <= cfg_i.wdata[EXT_W-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/core/nce_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nce_fifo
// Short first-in first-out queue between front and back, head shown
// directly at the output.
// ----------------------------------------------------------------------------
module nce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/nce_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nce_back
// Serializes each queued coordinate snapshot into one transaction per axis,
// outermost first, through a registered output stage.
// ----------------------------------------------------------------------------
module nce_back #(
  parameter int MAX_DIMS = 6
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      q_empty_i,
  input  logic [MAX_DIMS-1:0][nce_pkg::OUT_W-1:0]   q_coords_i,
  input  logic [nce_pkg::RANK_W-1:0]                q_rank_i,
  output logic                                      q_pop_o,
  nce_coord_if.source                               coord_o
);
  import nce_pkg::*;

  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [AXIS_W-1:0] idx_q;
  logic              valid_q;
  logic [OUT_W-1:0]  coord_q;
  logic [AXIS_W-1:0] axis_q;
  logic              last_q;
  logic              emit;
  logic              is_last;

  assign emit    = !q_empty_i && (!valid_q || coord_o.ready);
  assign is_last = (({1'b0, idx_q} + (AXIS_W + 1)'(1)) == {1'b0, q_rank_i});
  assign q_pop_o = emit && is_last;

  assign coord_o.valid      = valid_q;
  assign coord_o.coordinate = coord_q;
  assign coord_o.axis       = axis_q;
  assign coord_o.last_axis  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (emit) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + AXIS_W'(1);
      end else if (coord_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coord_q <= q_coords_i[idx_q[IDX_W-1:0]];
      axis_q  <= idx_q;
      last_q  <= is_last;
    end
  end

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (32'(axis_q) < MAX_DIMS))
    else $error("axis beyond configured dimensions");
  a_axis_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && coord_o.ready && !last_q) |=>
      (valid_q && (axis_q == $past(axis_q) + AXIS_W'(1))))
    else $error("coordinate run broken");
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !q_empty_i)
    else $error("entry left queue mid-run");

endmodule

// ===== rtl/core/nonzero_coordinate_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_coordinate_extractor
// Emits the per-axis coordinates of every nonzero element of a row-major
// tensor stream.
// ----------------------------------------------------------------------------
// The element port takes one element per cycle while the queue has room; the
// odometer advances in that same cycle. A nonzero element yields rank output
// transactions, one per cycle from the single output register while the
// consumer is ready, so a run of nonzero elements is paced by that stage.
// A four-entry queue between odometer and serializer absorbs bursts; zero
// elements produce nothing.
// ----------------------------------------------------------------------------
module nonzero_coordinate_extractor #(
  parameter int MAX_DIMS    = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nce_elem_if.sink     elem_i,
  nce_cfg_if.sink      cfg_i,
  nce_coord_if.source  coord_o
);
  import nce_pkg::*;

  localparam int ENTRY_W = MAX_DIMS * OUT_W + RANK_W;

  logic                             q_push, q_pop, q_full, q_empty;
  logic [MAX_DIMS-1:0][OUT_W-1:0]   push_coords, head_coords;
  logic [RANK_W-1:0]                push_rank, head_rank;
  logic [ENTRY_W-1:0]               push_data, head_data;

  assign push_data                 = {push_rank, push_coords};
  assign {head_rank, head_coords}  = head_data;

  nce_front #(
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .elem_i     (elem_i),
    .cfg_i      (cfg_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_coords_o (push_coords),
    .q_rank_o   (push_rank)
  );

  nce_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_data)
  );

  nce_back #(
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_coords_i (head_coords),
    .q_rank_i   (head_rank),
    .q_pop_o    (q_pop),
    .coord_o    (coord_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nonzero coordinate extractor.
// A directed table walks the element extremes, rank saturation, zero extents,
// wrap and an extent lowered mid-tensor. Random phases then re-program rank
// and extents.
// Every coordinate transaction is checked against an odometer model kept in
// the bench, with random valid and ready bursts on both streams.
// ----------------------------------------------------------------------------
module tb;
  import nce_pkg::*;

  localparam int MAX_DIMS      = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int MAX_REPORTS   = 60;
  localparam int NUM_ROWS      = 37;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ROW_ELEM, ROW_PINNED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [ELEM_W-1:0]    value;
    logic                 first;
    logic [CFG_IDX_W-1:0] idx;
    logic                 hit;
  } script_row_t;

  typedef struct packed {
    logic [OUT_W-1:0]  coordinate;
    logic [AXIS_W-1:0] axis;
    logic              last_axis;
  } coord_result_t;

  logic clk_i;
  logic rst_ni;

  nce_elem_if  elem ();
  nce_cfg_if   cfg ();
  nce_coord_if coord ();

  nonzero_coordinate_extractor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .elem_i  (elem),
    .cfg_i   (cfg),
    .coord_o (coord)
  );

  // odometer model
  logic [RANK_W-1:0] rank_reg = RANK_W'(1);
  logic [EXT_W-1:0]  extent_reg [EXT_REGS] = '{default: EXT_W'(1)};
  logic [OUT_W-1:0]  odometer [MAX_DIMS] = '{default: '0};
  coord_result_t     expected_coords [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  bit idle_on;
  bit pin_active;
  bit pin_hit;

  // rows before the first register write run with reset settings
  script_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_PINNED, 32'h0000_0001, 1'b1, REG_RANK, 1'b1},
    '{ROW_PINNED, 32'h0000_0000, 1'b0, REG_RANK, 1'b0},
    '{ROW_PINNED, 32'h7fff_ffff, 1'b0, REG_RANK, 1'b1},
    '{ROW_PINNED, 32'h8000_0000, 1'b0, REG_RANK, 1'b1},
    '{ROW_PINNED, 32'hffff_ffff, 1'b0, REG_RANK, 1'b1},
    '{ROW_CFG,    32'h0000_0007, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0002, 1'b0, REG_EXT0, 1'b0},
    '{ROW_CFG,    32'h0000_0001, 1'b0, REG_EXT1, 1'b0},
    '{ROW_CFG,    32'h0000_0003, 1'b0, REG_EXT2, 1'b0},
    '{ROW_CFG,    32'h0000_0000, 1'b0, REG_EXT3, 1'b0},
    '{ROW_CFG,    32'h0000_0002, 1'b0, REG_EXT4, 1'b0},
    '{ROW_CFG,    32'h0000_ffff, 1'b0, REG_EXT5, 1'b0},
    '{ROW_CFG,    32'h0000_ffff, 1'b0, REG_UNUSED, 1'b0},
    '{ROW_ELEM,   32'h0000_0005, 1'b1, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0000, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0001_0000, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'hffff_fff9, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0003, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h5555_5555, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0000, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0003, 1'b0, REG_EXT0, 1'b0},
    '{ROW_ELEM,   32'h0000_0002, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0004, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0006, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0008, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0002, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0004, 1'b0, REG_EXT1, 1'b0},
    '{ROW_ELEM,   32'h0000_0009, 1'b1, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_0000, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_000b, 1'b0, REG_RANK, 1'b0},
    // inner counter now sits above the new extent
    '{ROW_CFG,    32'h0000_0002, 1'b0, REG_EXT1, 1'b0},
    '{ROW_ELEM,   32'h0000_000c, 1'b0, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h0000_000d, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_0006, 1'b0, REG_RANK, 1'b0},
    '{ROW_CFG,    32'h0000_ffff, 1'b0, REG_EXT0, 1'b0},
    '{ROW_ELEM,   32'h8000_0001, 1'b1, REG_RANK, 1'b0},
    '{ROW_ELEM,   32'h7fff_fffe, 1'b0, REG_RANK, 1'b0}
  };

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == REG_RANK) begin
      rank_reg = data[RANK_W-1:0];
    end else if (idx <= REG_EXT5) begin
      extent_reg[idx - REG_EXT0] = data[EXT_W-1:0];
    end
  endfunction

  function automatic void queue_expected(coord_result_t res);
    expected_coords = {expected_coords, res};
  endfunction

  function automatic void track_element(logic [ELEM_W-1:0] value, logic first,
                                        bit record);
    int               r;
    logic [OUT_W-1:0] step;
    logic [EXT_W-1:0] lim;
    coord_result_t    res;
    r = (rank_reg == 0) ? 1 : ((rank_reg > MAX_DIMS) ? MAX_DIMS : int'(rank_reg));
    if (first) begin
      foreach (odometer[a]) odometer[a] = '0;
    end
    if (value != '0 && record) begin
      for (int a = 0; a < r; a++) begin
        res.coordinate = odometer[a];
        res.axis       = AXIS_W'(a);
        res.last_axis  = (a == r - 1);
        queue_expected(res);
      end
    end
    for (int k = r - 1; k >= 0; k--) begin
      lim  = (extent_reg[k] == '0) ? EXT_W'(1) : extent_reg[k];
      step = odometer[k] + 1'b1;
      if (step >= lim || step == '0) begin
        odometer[k] = '0;
      end else begin
        odometer[k] = step;
        break;
      end
    end
  endfunction

  function automatic int sender_gap();
    if (!idle_on || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hffff;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  // all tasks below start and end on a falling edge
  task automatic send_element(logic [ELEM_W-1:0] value, logic first, bit pinned,
                              bit hit);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      elem.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin_active = pinned;
    pin_hit    = hit;
    elem.valid         <= 1'b1;
    elem.element_value <= value;
    elem.first_element <= first;
    do @(posedge clk_i); while (!(elem.valid && elem.ready));
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    do @(posedge clk_i); while (!(cfg.valid && cfg.ready));
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    elem.valid <= 1'b0;
    while (expected_coords.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : result_stall
    int hold;
    hold        = 0;
    coord.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idle_on) begin
        coord.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        coord.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 3);
        coord.ready <= 1'b0;
      end else begin
        coord.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    coord_result_t got;
    coord_result_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        apply_register(cfg.reg_index, cfg.wdata);
        moved = 1'b1;
      end
      if (elem.valid && elem.ready) begin
        track_element(elem.element_value, elem.first_element, !pin_active);
        if (pin_active && pin_hit) queue_expected('{'0, '0, 1'b1});
        moved = 1'b1;
      end
      if (coord.valid && coord.ready) begin
        got.coordinate = coord.coordinate;
        got.axis       = coord.axis;
        got.last_axis  = coord.last_axis;
        moved          = 1'b1;
        if (expected_coords.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected transaction coordinate=%0d axis=%0d last=%0b",
                     $time, got.coordinate, got.axis, got.last_axis);
        end else begin
          want = expected_coords.pop_front();
          if (got.coordinate !== want.coordinate || got.axis !== want.axis ||
              got.last_axis !== want.last_axis) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected coordinate=%0d axis=%0d last=%0b, %s%0d %s%0d %s%0b",
                       $time, want.coordinate, want.axis, want.last_axis,
                       "got coordinate=", got.coordinate, "axis=", got.axis,
                       "last=", got.last_axis);
          end
        end
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    elem.valid         = 1'b0;
    elem.element_value = '0;
    elem.first_element = 1'b0;
    cfg.valid          = 1'b0;
    cfg.reg_index      = REG_RANK;
    cfg.wdata          = '0;
    idle_on            = 1'b1;
    pin_active         = 1'b0;
    pin_hit            = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(directed_rows[i].idx, directed_rows[i].value[CFG_DATA_W-1:0]);
      end else begin
        send_element(directed_rows[i].value, directed_rows[i].first,
                     directed_rows[i].kind == ROW_PINNED, directed_rows[i].hit);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      write_register(REG_RANK, CFG_DATA_W'($urandom));
      for (int a = 0; a < EXT_REGS; a++)
        write_register(CFG_IDX_W'(REG_EXT0 + a), pick_extent());
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, CFG_DATA_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) wait_idle();
        send_element(pick_value(),
                     (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0),
                     1'b0, 1'b0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nce_pkg.sv
rtl/core/nce_if.sv
rtl/core/nce_front.sv
rtl/core/nce_fifo.sv
rtl/core/nce_back.sv
rtl/core/nonzero_coordinate_extractor.sv
sim/tb.sv
